>>> design/tpcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_pkg: shared types and constants
// Types and fixed constants used by the controller, the datapath and the top
// level of the threshold-promoted move-to-front cache list.
// ----------------------------------------------------------------------------
package tpcl_pkg;

	localparam int COUNT_W = 16;
	localparam int CAP_W   = 5;
	localparam int CFG_W   = 16;
	localparam int OCC_W   = 5;
	localparam int PORT_KEY_W = 32;
	// Width used for comparing fill level against capacity; holds 64 and more.
	localparam int LVL_W   = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_ONE  = 16'd1;
	localparam logic [COUNT_W-1:0] THR_RESET  = 16'd2;
	localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_CAPACITY  = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic update;
	} cmd_t;

endpackage

>>> design/tpcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_ctrl: request sequencer
// Walks each request through a compare cycle and an update cycle and issues
// the matching commands to the datapath.
// ----------------------------------------------------------------------------
module tpcl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output tpcl_pkg::cmd_t  cmd
);

	tpcl_pkg::state_t state_q;
	tpcl_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpcl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tpcl_pkg::ST_IDLE: begin
				if (start) state_nxt = tpcl_pkg::ST_CMP;
			end
			tpcl_pkg::ST_CMP: begin
				state_nxt = tpcl_pkg::ST_UPD;
			end
			tpcl_pkg::ST_UPD: begin
				// A new request may enter while this one is being written back.
				state_nxt = start ? tpcl_pkg::ST_CMP : tpcl_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = tpcl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		cmd.load    = 1'b0;
		cmd.compare = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			tpcl_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			tpcl_pkg::ST_CMP: begin
				busy        = 1'b1;
				cmd.compare = 1'b1;
			end
			tpcl_pkg::ST_UPD: begin
				cmd.load   = start;
				cmd.update = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

>>> design/tpcl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_datapath: entry cells, key compare and list update
// Holds the ordered entry cells, compares the request key against all of
// them in parallel, then shifts or updates the cells and registers the result.
// ----------------------------------------------------------------------------
module tpcl_datapath #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tpcl_pkg::cmd_t                       cmd,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [tpcl_pkg::CFG_W-1:0]           cfg_data,
	input  logic [tpcl_pkg::PORT_KEY_W-1:0]      page_key,
	output logic                                 done,
	output logic                                 hit,
	output logic                                 promoted,
	output logic [tpcl_pkg::COUNT_W-1:0]         entry_count,
	output logic                                 evicted_valid,
	output logic [tpcl_pkg::PORT_KEY_W-1:0]      evicted_key,
	output logic [tpcl_pkg::OCC_W-1:0]           occupancy
);

	localparam int FW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LW = tpcl_pkg::LVL_W;

	// Configuration.
	logic [tpcl_pkg::COUNT_W-1:0] thr_q;
	logic [tpcl_pkg::CAP_W-1:0]   cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tpcl_pkg::THR_RESET;
			cap_q <= tpcl_pkg::CAP_RESET;
		end else if (cfg_we) begin
			unique case (tpcl_pkg::reg_index_t'(cfg_index))
				tpcl_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				tpcl_pkg::REG_CAPACITY:  cap_q <= cfg_data[tpcl_pkg::CAP_W-1:0];
				default:                 thr_q <= thr_q;
			endcase
		end
	end

	// Request key and entry cells.
	logic [KEY_BITS-1:0]          key_q;
	logic [KEY_BITS-1:0]          cell_key_q [MAX_ENTRIES];
	logic [tpcl_pkg::COUNT_W-1:0] cell_cnt_q [MAX_ENTRIES];
	logic [FW-1:0]                fill_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= KEY_BITS'(page_key);
		end
	end

	// Compare cycle.
	logic [LW-1:0]                fill_lvl;
	logic [LW-1:0]                cap_lvl;
	logic [LW-1:0]                eff_cap;
	logic [MAX_ENTRIES-1:0]       match;
	logic [MAX_ENTRIES-1:0]       shift_vec;
	logic [tpcl_pkg::COUNT_W-1:0] cnt_sel;
	logic [tpcl_pkg::COUNT_W-1:0] cnt_inc;
	logic                         any_hit;
	logic                         do_promote;
	logic                         do_evict;
	logic [IW-1:0]                tail_idx;
	logic [IW-1:0]                prev_idx;
	logic [KEY_BITS-1:0]          tail_key;

	assign fill_lvl = LW'(fill_q);
	assign cap_lvl  = LW'(cap_q);
	assign tail_idx = IW'(fill_q - FW'(1));
	assign prev_idx = IW'(fill_q - FW'(2));

	always_comb begin
		if (cap_lvl == '0) begin
			eff_cap = LW'(1);
		end else if (cap_lvl > LW'(MAX_ENTRIES)) begin
			eff_cap = LW'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_lvl;
		end
	end

	always_comb begin
		cnt_sel = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = (LW'(i) < fill_lvl) && (cell_key_q[i] == key_q);
			cnt_sel  = cnt_sel | (cell_cnt_q[i] & {tpcl_pkg::COUNT_W{match[i]}});
		end
		// A cell shifts on promotion when it lies at or ahead of the hit entry.
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			shift_vec[i] = |(match >> i);
		end
	end

	assign any_hit    = |match;
	assign cnt_inc    = (cnt_sel == tpcl_pkg::COUNT_MAX) ? cnt_sel
	                  : cnt_sel + tpcl_pkg::COUNT_ONE;
	assign do_promote = any_hit && (cnt_inc > thr_q);
	assign do_evict   = any_hit ? (do_promote && (fill_lvl > eff_cap))
	                  : (fill_lvl >= eff_cap);
	// When the tail entry itself is promoted, the entry ahead of it becomes the tail.
	assign tail_key   = (do_promote && match[tail_idx]) ? cell_key_q[prev_idx]
	                  : cell_key_q[tail_idx];

	logic                         hit_s1;
	logic                         promote_s1;
	logic                         evict_s1;
	logic [MAX_ENTRIES-1:0]       match_s1;
	logic [MAX_ENTRIES-1:0]       shift_s1;
	logic [tpcl_pkg::COUNT_W-1:0] cnt_s1;
	logic [KEY_BITS-1:0]          evkey_s1;

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			hit_s1     <= any_hit;
			promote_s1 <= do_promote;
			evict_s1   <= do_evict;
			match_s1   <= match;
			shift_s1   <= shift_vec;
			cnt_s1     <= cnt_inc;
			evkey_s1   <= tail_key;
		end
	end

	// Update cycle: cell writes.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.update) begin
					if (!hit_s1 || promote_s1) begin
						cell_key_q[i] <= key_q;
						cell_cnt_q[i] <= hit_s1 ? cnt_s1 : tpcl_pkg::COUNT_ONE;
					end else if (match_s1[i]) begin
						cell_cnt_q[i] <= cnt_s1;
					end
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (cmd.update) begin
					if (!hit_s1 || (promote_s1 && shift_s1[i])) begin
						cell_key_q[i] <= cell_key_q[i-1];
						cell_cnt_q[i] <= cell_cnt_q[i-1];
					end else if (!promote_s1 && match_s1[i]) begin
						cell_cnt_q[i] <= cnt_s1;
					end
				end
			end
		end
	end

	logic [FW-1:0] fill_nxt;

	always_comb begin
		fill_nxt = fill_q;
		if (!hit_s1) begin
			if (!evict_s1) fill_nxt = fill_q + FW'(1);
		end else if (evict_s1) begin
			fill_nxt = fill_q - FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.update;
			if (cmd.update) fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit           <= hit_s1;
			promoted      <= promote_s1;
			entry_count   <= hit_s1 ? cnt_s1 : tpcl_pkg::COUNT_ONE;
			evicted_valid <= evict_s1;
			evicted_key   <= evict_s1 ? tpcl_pkg::PORT_KEY_W'(evkey_s1) : '0;
			occupancy     <= tpcl_pkg::OCC_W'(fill_nxt);
		end
	end

endmodule

>>> design/threshold_promote_cache_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_promote_cache_list: threshold-promoted move-to-front cache list
// Ordered list of page keys with hit counts; hits count up and move to the
// front past a threshold, misses insert at the front and may evict the tail.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  request   start, busy              page_key
//  result    done (one-cycle strobe)  hit, promoted, entry_count,
//                                     evicted_valid, evicted_key, occupancy
//  config    cfg_we                   cfg_index, cfg_data
//
//  A request takes a compare cycle (all cells in parallel) and an update
//  cycle (shift or count write); busy is high only during the compare cycle,
//  so a new request can be taken in the update cycle of the one before.
//  The key is registered on acceptance, the compare result at the end of
//  the compare cycle, and done and the result at the end of the update cycle.
//  Reset clears the list and loads threshold 2 and capacity 16.
//  The receiver cannot stall; done marks each result for one cycle only.
// ----------------------------------------------------------------------------
module threshold_promote_cache_list #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tpcl_pkg::PORT_KEY_W-1:0]      page_key,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [tpcl_pkg::CFG_W-1:0]           cfg_data,
	output logic                                 done,
	output logic                                 hit,
	output logic                                 promoted,
	output logic [tpcl_pkg::COUNT_W-1:0]         entry_count,
	output logic                                 evicted_valid,
	output logic [tpcl_pkg::PORT_KEY_W-1:0]      evicted_key,
	output logic [tpcl_pkg::OCC_W-1:0]           occupancy
);

	tpcl_pkg::cmd_t cmd;

	tpcl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	tpcl_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.page_key      (page_key),
		.done          (done),
		.hit           (hit),
		.promoted      (promoted),
		.entry_count   (entry_count),
		.evicted_valid (evicted_valid),
		.evicted_key   (evicted_key),
		.occupancy     (occupancy)
	);

endmodule

>>> design/tpcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_checker: port-level checks
// Checks request timing and result consistency as seen on the top level.
// ----------------------------------------------------------------------------
module tpcl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic                            hit,
	input logic                            promoted,
	input logic [tpcl_pkg::COUNT_W-1:0]    entry_count,
	input logic                            evicted_valid,
	input logic [tpcl_pkg::PORT_KEY_W-1:0] evicted_key,
	input logic [tpcl_pkg::OCC_W-1:0]      occupancy
);

	// Every accepted request produces a done strobe once its update state ends.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after request");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching request");

	// The compare phase lasts a single cycle.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// A miss always leaves the new key in the list with a count of one.
	a_miss_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (!promoted && entry_count == 16'd1 && occupancy != '0))
		else $error("inconsistent miss result");

	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted_valid) |-> (evicted_key == '0))
		else $error("evicted key set without an eviction");

endmodule

bind threshold_promote_cache_list tpcl_checker u_tpcl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.promoted      (promoted),
	.entry_count   (entry_count),
	.evicted_valid (evicted_valid),
	.evicted_key   (evicted_key),
	.occupancy     (occupancy)
);

>>> test/threshold_promote_cache_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_promote_cache_list_tb: self-checking bench for the cache list
// Walks a short table of directed lookups and register writes, then runs
// random phases over a small key pool. Every accepted lookup runs through a
// local model of the list; each done strobe is checked field by field against
// the oldest expectation, from the table for typed rows, else from the model.
// ----------------------------------------------------------------------------
module threshold_promote_cache_list_tb;

	localparam int LIST_DEPTH   = 16;
	localparam int POOL_SIZE    = 24;
	localparam int RANDOM_ITEMS = 1100;
	localparam int LIMIT_CYCLES = 1_000_000;

	typedef struct packed {
		logic                            hit;
		logic                            promoted;
		logic [tpcl_pkg::COUNT_W-1:0]    count;
		logic                            ev_valid;
		logic [tpcl_pkg::PORT_KEY_W-1:0] ev_key;
		logic [tpcl_pkg::OCC_W-1:0]      occ;
	} lookup_res_t;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		tpcl_pkg::reg_index_t            idx;
		logic [tpcl_pkg::CFG_W-1:0]      data;
		logic [tpcl_pkg::PORT_KEY_W-1:0] key;
		logic                            typed;
		lookup_res_t                     res;
	} dir_row_t;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            start     = 1'b0;
	logic [tpcl_pkg::PORT_KEY_W-1:0] page_key  = '0;
	logic                            cfg_we    = 1'b0;
	logic                            cfg_index = 1'b0;
	logic [tpcl_pkg::CFG_W-1:0]      cfg_data  = '0;
	logic                            busy;
	logic                            done;
	logic                            hit;
	logic                            promoted;
	logic [tpcl_pkg::COUNT_W-1:0]    entry_count;
	logic                            evicted_valid;
	logic [tpcl_pkg::PORT_KEY_W-1:0] evicted_key;
	logic [tpcl_pkg::OCC_W-1:0]      occupancy;

	threshold_promote_cache_list u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_key      (page_key),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.hit           (hit),
		.promoted      (promoted),
		.entry_count   (entry_count),
		.evicted_valid (evicted_valid),
		.evicted_key   (evicted_key),
		.occupancy     (occupancy)
	);

	// Local copy of the list, front at slot 0, and of the registers.
	logic [tpcl_pkg::PORT_KEY_W-1:0] list_key [LIST_DEPTH];
	logic [tpcl_pkg::COUNT_W-1:0]    list_cnt [LIST_DEPTH];
	int                              list_fill = 0;
	logic [tpcl_pkg::COUNT_W-1:0]    thr_reg   = tpcl_pkg::THR_RESET;
	logic [tpcl_pkg::CAP_W-1:0]      cap_reg   = tpcl_pkg::CAP_RESET;

	lookup_res_t                     pending_lookups [$];
	dir_row_t                        dir_tab [$];
	logic [tpcl_pkg::PORT_KEY_W-1:0] key_pool [POOL_SIZE];
	lookup_res_t                     got_res;
	lookup_res_t                     exp_res;
	int                              mismatches  = 0;
	int                              cycle_count = 0;
	int                              burst_left  = 0;
	bit                              gaps_on     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic lookup_res_t lookup_model(
			input logic [tpcl_pkg::PORT_KEY_W-1:0] key);
		lookup_res_t                  r;
		int                           lim;
		int                           pos;
		int                           n;
		int                           i;
		logic                         found;
		logic [tpcl_pkg::COUNT_W-1:0] c;
		lim = int'(cap_reg);
		if (lim < 1)
			lim = 1;
		if (lim > LIST_DEPTH)
			lim = LIST_DEPTH;
		r = '0;
		r.count = tpcl_pkg::COUNT_ONE;
		found = 1'b0;
		pos = 0;
		for (i = 0; i < list_fill; i++) begin
			if (!found && list_key[i] == key) begin
				found = 1'b1;
				pos = i;
			end
		end
		if (found) begin
			c = list_cnt[pos];
			if (c != tpcl_pkg::COUNT_MAX)
				c = c + tpcl_pkg::COUNT_ONE;
			r.hit = 1'b1;
			r.count = c;
			if (c > thr_reg) begin
				r.promoted = 1'b1;
				for (i = pos; i > 0; i--) begin
					list_key[i] = list_key[i-1];
					list_cnt[i] = list_cnt[i-1];
				end
				list_key[0] = key;
				list_cnt[0] = c;
				// A promoting hit trims one tail entry if capacity was lowered.
				if (list_fill > lim) begin
					r.ev_valid = 1'b1;
					r.ev_key = list_key[list_fill-1];
					list_fill--;
				end
			end else begin
				list_cnt[pos] = c;
			end
		end else begin
			n = list_fill + 1;
			if (n > lim) begin
				r.ev_valid = 1'b1;
				r.ev_key = list_key[list_fill-1];
				n--;
			end
			for (i = n - 1; i > 0; i--) begin
				list_key[i] = list_key[i-1];
				list_cnt[i] = list_cnt[i-1];
			end
			list_key[0] = key;
			list_cnt[0] = tpcl_pkg::COUNT_ONE;
			list_fill = n;
		end
		r.occ = list_fill[tpcl_pkg::OCC_W-1:0];
		return r;
	endfunction

	function automatic void add_req(input logic [tpcl_pkg::PORT_KEY_W-1:0] key,
			input logic typed, input logic h, input logic p,
			input logic [tpcl_pkg::COUNT_W-1:0] c, input logic ev,
			input logic [tpcl_pkg::PORT_KEY_W-1:0] ek,
			input logic [tpcl_pkg::OCC_W-1:0] occ);
		dir_row_t r;
		r.kind  = ROW_REQ;
		r.idx   = tpcl_pkg::REG_THRESHOLD;
		r.data  = '0;
		r.key   = key;
		r.typed = typed;
		r.res   = {h, p, c, ev, ek, occ};
		dir_tab.push_back(r);
	endfunction

	function automatic void add_cfg(input tpcl_pkg::reg_index_t idx,
			input logic [tpcl_pkg::CFG_W-1:0] data);
		dir_row_t r;
		r       = '0;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.data  = data;
		dir_tab.push_back(r);
	endfunction

	// Holds start high until the request is taken, then records the expected result.
	task automatic send_lookup(input logic [tpcl_pkg::PORT_KEY_W-1:0] key,
			input logic typed, input lookup_res_t typed_res);
		lookup_res_t pred;
		start    <= 1'b1;
		page_key <= key;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pred = lookup_model(key);
		pending_lookups.push_back(typed ? typed_res : pred);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input tpcl_pkg::reg_index_t idx,
			input logic [tpcl_pkg::CFG_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tpcl_pkg::REG_THRESHOLD)
			thr_reg = data;
		else
			cap_reg = data[tpcl_pkg::CAP_W-1:0];
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			got_res = {hit, promoted, entry_count, evicted_valid, evicted_key, occupancy};
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at cycle %0d: %p", cycle_count, got_res);
			end else begin
				exp_res = pending_lookups.pop_front();
				if (got_res.hit !== exp_res.hit || got_res.promoted !== exp_res.promoted ||
						got_res.count !== exp_res.count ||
						got_res.ev_valid !== exp_res.ev_valid ||
						got_res.ev_key !== exp_res.ev_key || got_res.occ !== exp_res.occ) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  expected hit=%0d promoted=%0d count=%0d ev=%0d key=%h occ=%0d",
							exp_res.hit, exp_res.promoted, exp_res.count, exp_res.ev_valid,
							exp_res.ev_key, exp_res.occ);
						$display("  actual   hit=%0d promoted=%0d count=%0d ev=%0d key=%h occ=%0d",
							got_res.hit, got_res.promoted, got_res.count, got_res.ev_valid,
							got_res.ev_key, got_res.occ);
					end
				end
			end
		end
	end

	initial begin
		int                              sent;
		int                              lim;
		int                              pool_n;
		int                              len;
		logic [tpcl_pkg::CFG_W-1:0]      thr_val;
		logic [tpcl_pkg::CFG_W-1:0]      cap_val;
		logic [tpcl_pkg::PORT_KEY_W-1:0] key;

		// Directed table: reset values first, then threshold and capacity corners.
		add_req(32'h0000_0000, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 32'h0, 5'd1);
		add_req(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 32'h0, 5'd2);
		add_req(32'h0000_0000, 1'b1, 1'b1, 1'b0, 16'd2, 1'b0, 32'h0, 5'd2);
		add_req(32'h0000_0000, 1'b1, 1'b1, 1'b1, 16'd3, 1'b0, 32'h0, 5'd2);
		add_req(32'h0000_0000, 1'b1, 1'b1, 1'b1, 16'd4, 1'b0, 32'h0, 5'd2);
		add_cfg(tpcl_pkg::REG_THRESHOLD, 16'h0000);
		add_req(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'd2, 1'b0, 32'h0, 5'd2);
		add_cfg(tpcl_pkg::REG_THRESHOLD, 16'hFFFF);
		add_req(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'd3, 1'b0, 32'h0, 5'd2);
		// Capacity zero acts as one; the evicted key here is itself zero.
		add_cfg(tpcl_pkg::REG_CAPACITY, 16'h0000);
		add_req(32'h1234_5678, 1'b1, 1'b0, 1'b0, 16'd1, 1'b1, 32'h0, 5'd2);
		add_req(32'h1234_5678, 1'b1, 1'b1, 1'b0, 16'd2, 1'b0, 32'h0, 5'd2);
		add_cfg(tpcl_pkg::REG_THRESHOLD, 16'h0001);
		add_req(32'h1234_5678, 1'b1, 1'b1, 1'b1, 16'd3, 1'b1, 32'hFFFF_FFFF, 5'd1);
		add_req(32'hA5A5_A5A5, 1'b1, 1'b0, 1'b0, 16'd1, 1'b1, 32'h1234_5678, 5'd1);
		add_cfg(tpcl_pkg::REG_CAPACITY, 16'hFFFF);
		add_req(32'h0000_0001, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 32'h0, 5'd2);
		add_req(32'h8000_0000, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 32'h0, 5'd0);
		add_cfg(tpcl_pkg::REG_CAPACITY, 16'h0002);
		add_req(32'h0000_0001, 1'b1, 1'b1, 1'b1, 16'd2, 1'b1, 32'hA5A5_A5A5, 5'd2);
		add_cfg(tpcl_pkg::REG_CAPACITY, 16'h0010);
		add_cfg(tpcl_pkg::REG_THRESHOLD, 16'h0002);
		add_req(32'h0000_0001, 1'b1, 1'b1, 1'b1, 16'd3, 1'b0, 32'h0, 5'd2);

		for (int k = 0; k < POOL_SIZE; k++)
			key_pool[k] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		foreach (dir_tab[k]) begin
			if (dir_tab[k].kind == ROW_CFG)
				write_reg(dir_tab[k].idx, dir_tab[k].data);
			else
				send_lookup(dir_tab[k].key, dir_tab[k].typed, dir_tab[k].res);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: thr_val = 16'h0000;
				1: thr_val = 16'h0001;
				2: thr_val = tpcl_pkg::CFG_W'($urandom_range(2, 4));
				3: thr_val = tpcl_pkg::CFG_W'($urandom_range(0, 10));
				4: thr_val = 16'hFFFF;
				default: thr_val = tpcl_pkg::CFG_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: cap_val = 16'h0000;
				1: cap_val = 16'h0001;
				2: cap_val = 16'h0010;
				3: cap_val = tpcl_pkg::CFG_W'($urandom_range(2, 15));
				4: cap_val = tpcl_pkg::CFG_W'($urandom_range(17, 31));
				default: cap_val = tpcl_pkg::CFG_W'($urandom_range(1, 16));
			endcase
			// Bits above the capacity field are don't-care on the write port.
			if ($urandom_range(0, 1))
				cap_val[tpcl_pkg::CFG_W-1:tpcl_pkg::CAP_W] =
					(tpcl_pkg::CFG_W - tpcl_pkg::CAP_W)'($urandom);
			if ($urandom_range(0, 1)) begin
				write_reg(tpcl_pkg::REG_THRESHOLD, thr_val);
				write_reg(tpcl_pkg::REG_CAPACITY, cap_val);
			end else begin
				write_reg(tpcl_pkg::REG_CAPACITY, cap_val);
				write_reg(tpcl_pkg::REG_THRESHOLD, thr_val);
			end

			repeat ($urandom_range(1, 8))
				key_pool[$urandom_range(0, POOL_SIZE - 1)] =
					($urandom_range(0, 9) == 0)
						? {tpcl_pkg::PORT_KEY_W{$urandom_range(0, 1) == 1}}
						: $urandom;
			lim = int'(cap_reg);
			if (lim < 1)
				lim = 1;
			if (lim > LIST_DEPTH)
				lim = LIST_DEPTH;
			pool_n = lim + $urandom_range(0, 4);
			if (pool_n > POOL_SIZE)
				pool_n = POOL_SIZE;

			gaps_on = ($urandom_range(0, 3) != 0);
			len = $urandom_range(20, 110);
			repeat (len) begin
				if ($urandom_range(0, 99) < 85)
					key = key_pool[$urandom_range(0, pool_n - 1)];
				else
					key = $urandom;
				send_lookup(key, 1'b0, '0);
				sent++;
				if ($urandom_range(0, 39) == 0)
					drain();
				else
					pace();
			end
		end

		drain();
		repeat (8)
			@(posedge clk);
		if (mismatches == 0 && pending_lookups.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
